### rtl/ctmh_pkg.sv
`default_nettype none

package ctmh_pkg;

    // Largest pattern, in sequence bytes, that the block will hash.
    localparam int MAX_PATTERN_BYTES = 64;

    // Width of the byte position and used-count registers.
    localparam int POS_W = 7;

    // Saturation value of the byte position, and the used-count mark for an oversized pattern.
    localparam logic [POS_W-1:0] POS_SAT = 7'd127;

    // Hash constants.
    localparam logic [31:0] MUR_M    = 32'h5bd1e995;
    localparam logic [31:0] MUR_SEED = 32'hdeadbeef;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_PIXELS = 2'd1;
    localparam logic [1:0] ST_OVER_CAP  = 2'd2;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_TAKE,
        OP_MIX1,
        OP_MIX2,
        OP_MIX3,
        OP_FIN1,
        OP_FIN2,
        OP_EMIT
    } dp_op_t;

    // Source of the byte fed to the hash.
    typedef enum logic [1:0] {
        SEL_ROW,
        SEL_COL,
        SEL_PAT,
        SEL_ZERO
    } byte_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ROW,
        S_COL,
        S_PAT,
        S_MIX1,
        S_MIX2,
        S_MIX3,
        S_PAD,
        S_FIN1,
        S_FIN2,
        S_EMIT
    } ctrl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic      capture;
        dp_op_t    op;
        byte_sel_t sel;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic in_topo;
        logic ok;
        logic last;
        logic pos_lt_used;
        logic word_full;
        logic tail_nz;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/ctmh_ctrl.sv
`default_nettype none

module ctmh_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire ctmh_pkg::dp_stat_t stat,
    output ctmh_pkg::dp_cmd_t       cmd
);
    import ctmh_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    ctrl_state_t ret_reg;
    ctrl_state_t ret_next;
    ctrl_state_t succ;

    // State and return-point registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        succ        = S_IDLE;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.op      = OP_NOP;
        cmd.sel     = SEL_ZERO;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.in_topo ? S_PAT : S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_ROW;
            end
            S_ROW, S_COL, S_PAT:
            begin
                if (state_reg == S_ROW)
                begin
                    succ    = S_COL;
                    cmd.sel = SEL_ROW;
                end
                else if (state_reg == S_COL)
                begin
                    succ    = S_PAT;
                    cmd.sel = SEL_COL;
                end
                else
                begin
                    succ    = stat.last ? S_PAD : S_IDLE;
                    cmd.sel = SEL_PAT;
                end
                if (!stat.ok)
                begin
                    // Empty or oversized pattern: bytes are dropped until the last one.
                    state_next = stat.last ? S_EMIT : S_IDLE;
                end
                else
                begin
                    cmd.op = OP_TAKE;
                    if (stat.word_full)
                    begin
                        state_next = S_MIX1;
                        ret_next   = succ;
                    end
                    else
                    begin
                        state_next = succ;
                    end
                end
            end
            S_MIX1:
            begin
                cmd.op     = OP_MIX1;
                state_next = S_MIX2;
            end
            S_MIX2:
            begin
                cmd.op     = OP_MIX2;
                state_next = S_MIX3;
            end
            S_MIX3:
            begin
                cmd.op     = OP_MIX3;
                state_next = ret_reg;
            end
            S_PAD:
            begin
                // Missing bytes up to the used count hash as zeros.
                if (stat.pos_lt_used)
                begin
                    cmd.op  = OP_TAKE;
                    cmd.sel = SEL_ZERO;
                    if (stat.word_full)
                    begin
                        state_next = S_MIX1;
                        ret_next   = S_PAD;
                    end
                end
                else
                begin
                    state_next = stat.tail_nz ? S_FIN1 : S_FIN2;
                end
            end
            S_FIN1:
            begin
                cmd.op     = OP_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.op     = OP_FIN2;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/ctmh_dpath.sv
`default_nettype none

module ctmh_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         row_span,
    input  wire logic [7:0]         col_span,
    input  wire logic [7:0]         pattern_byte,
    input  wire logic               last_byte,
    input  wire ctmh_pkg::dp_cmd_t  cmd,
    output ctmh_pkg::dp_stat_t      stat,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [63:0]             topology_key,
    output logic [1:0]              status
);
    import ctmh_pkg::*;

    // Captured item.
    logic [7:0]       row_reg;
    logic [7:0]       col_reg;
    logic [7:0]       pat_reg;
    logic             last_reg;

    // Hash state.
    logic             in_topo_reg;
    logic [31:0]      hash_reg;
    logic [31:0]      k_reg;
    logic [23:0]      word_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] used_reg;
    logic [31:0]      lead_reg;

    // Output register.
    logic             out_valid_reg;
    logic [63:0]      key_reg;
    logic [1:0]       status_reg;

    logic [15:0]      span_prod;
    logic [15:0]      span_sum;
    logic [12:0]      used_full;
    logic [POS_W-1:0] used_init;
    logic [7:0]       take_b;
    logic [1:0]       lane;
    logic             pos_lt_used;
    logic [POS_W-1:0] lead_idx;
    logic             lead_hit;
    logic [31:0]      mul_a;
    logic [31:0]      mul_p;
    logic [31:0]      hash_fin;
    logic             ok;
    logic             out_free;

    // Used byte count from the spans, saturated to the oversize mark.
    assign span_prod = {8'b0, row_reg} * {8'b0, col_reg};
    assign span_sum  = span_prod + 16'd7;
    assign used_full = span_sum[15:3];
    assign used_init = (used_full > 13'(MAX_PATTERN_BYTES)) ? POS_SAT : used_full[POS_W-1:0];

    // Byte feed decode.
    always_comb
    begin
        case (cmd.sel)
            SEL_ROW:  take_b = row_reg;
            SEL_COL:  take_b = col_reg;
            SEL_PAT:  take_b = pat_reg;
            default:  take_b = 8'd0;
        endcase
    end

    assign lane        = pos_reg[1:0];
    assign pos_lt_used = pos_reg < used_reg;
    assign lead_idx    = pos_reg - 7'd2;
    assign lead_hit    = (pos_reg >= 7'd2) && (lead_idx < 7'd4) && (lead_idx < used_reg);
    assign ok          = (used_reg != '0) && (used_reg <= POS_W'(MAX_PATTERN_BYTES));
    assign out_free    = !out_valid_reg || out_ready;

    // Shared multiplier by the hash constant; operand picked by operation.
    always_comb
    begin
        case (cmd.op)
            OP_MIX1: mul_a = k_reg;
            OP_MIX2: mul_a = k_reg ^ (k_reg >> 24);
            OP_MIX3: mul_a = hash_reg;
            OP_FIN1: mul_a = hash_reg ^ {8'b0, word_reg};
            OP_FIN2: mul_a = hash_reg ^ (hash_reg >> 13);
            default: mul_a = k_reg;
        endcase
    end
    assign mul_p    = mul_a * MUR_M;
    assign hash_fin = hash_reg ^ (hash_reg >> 15);

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg  <= row_span;
            col_reg  <= col_span;
            pat_reg  <= pattern_byte;
            last_reg <= last_byte;
        end
    end

    // Hash state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_topo_reg   <= 1'b0;
            hash_reg      <= '0;
            k_reg         <= '0;
            word_reg      <= '0;
            pos_reg       <= '0;
            used_reg      <= '0;
            lead_reg      <= '0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            // A taken result beat frees the register unless a new key lands the same cycle.
            if (out_valid_reg && out_ready && (cmd.op != OP_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_INIT:
                begin
                    in_topo_reg <= 1'b1;
                    used_reg    <= used_init;
                    hash_reg    <= {25'b0, used_init} ^ MUR_SEED;
                    word_reg    <= '0;
                    pos_reg     <= '0;
                    lead_reg    <= '0;
                end
                OP_TAKE:
                begin
                    if (pos_lt_used)
                    begin
                        if (lane == 2'd3)
                        begin
                            k_reg    <= {take_b, word_reg};
                            word_reg <= '0;
                        end
                        else
                        begin
                            word_reg <= word_reg | (24'(take_b) << {lane, 3'b0});
                        end
                    end
                    if (lead_hit)
                    begin
                        lead_reg <= lead_reg | (32'(take_b) << {~lead_idx[1:0], 3'b0});
                    end
                    if (pos_reg != POS_SAT)
                    begin
                        pos_reg <= pos_reg + 7'd1;
                    end
                end
                OP_MIX1, OP_MIX2:
                begin
                    k_reg <= mul_p;
                end
                OP_MIX3:
                begin
                    hash_reg <= mul_p ^ k_reg;
                end
                OP_FIN1, OP_FIN2:
                begin
                    hash_reg <= mul_p;
                end
                OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    in_topo_reg   <= 1'b0;
                    if (ok)
                    begin
                        key_reg    <= {hash_fin, lead_reg};
                        status_reg <= ST_OK;
                    end
                    else
                    begin
                        key_reg    <= '0;
                        status_reg <= (used_reg == '0) ? ST_NO_PIXELS : ST_OVER_CAP;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.in_topo     = in_topo_reg;
        stat.ok          = ok;
        stat.last        = last_reg;
        stat.pos_lt_used = pos_lt_used;
        stat.word_full   = pos_lt_used && (lane == 2'd3);
        stat.tail_nz     = used_reg[1:0] != 2'd0;
        stat.out_free    = out_free;
    end

    assign out_valid    = out_valid_reg;
    assign topology_key = key_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

### rtl/cluster_topology_murmur2_hash.sv
`default_nettype none

// Cluster topology key generator. Each input beat carries one pattern byte; the
// row and column spans are sampled on the first beat of a topology, and the
// beat with tlast set closes it and produces one result beat. The key holds the
// 32-bit MurmurHash2 (seed 0xdeadbeef) of the row, column and pattern bytes,
// cut at ceil(rows*cols/8) bytes, in its upper half and up to four leading
// pattern bytes, big-endian, in its lower half. A topology with no pixels or
// with more than 64 used bytes gives a zero key and a nonzero status. One shared
// 32-bit multiplier does the hashing, and a new beat is taken only once the last
// one is through; every fourth hashed byte adds the word-mix steps MIX1, MIX2 and
// MIX3. The first beat adds the span setup and the two span bytes, and the last
// beat adds a zero byte per missing byte up to the used count, the same word mix
// on those bytes, and the finalization steps (FIN1 if a tail is left, then FIN2).
// A finished key waits in an output register while the next topology is taken in.
module cluster_topology_murmur2_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // row_span, col_span, pattern_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // topology_key
    output logic [1:0]       m_tuser    // status
);
    import ctmh_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ctmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ctmh_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_span     (s_tdata[7:0]),
        .col_span     (s_tdata[15:8]),
        .pattern_byte (s_tdata[23:16]),
        .last_byte    (s_tlast),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .topology_key (m_tdata),
        .status       (m_tuser)
    );

endmodule

`default_nettype wire

### tb/topology_key_checker.sv
module topology_key_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // row_span, col_span, pattern_byte
    input  wire logic        s_tlast,   // last_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,   // topology_key
    input  wire logic [1:0]  m_tuser,   // status
    output int               fail_count,
    output int               pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import ctmh_pkg::*;

    typedef struct packed {
        logic [63:0] key;
        logic [1:0]  status;
    } key_result_t;

    // Predicted hashing state of the topology in progress.
    logic [31:0] hash_acc;
    logic [23:0] tail_bytes;
    logic [6:0]  seq_pos;
    logic [6:0]  used_bytes;
    logic [31:0] lead_bytes;
    logic        open_topo;

    key_result_t expected_keys[$];

    function automatic logic [31:0] murmur_mix(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] kk;
        kk = k * MUR_M;
        kk = kk ^ (kk >> 24);
        kk = kk * MUR_M;
        return (h * MUR_M) ^ kk;
    endfunction

    function automatic void clear_topology();
        hash_acc   = '0;
        tail_bytes = '0;
        seq_pos    = '0;
        used_bytes = '0;
        lead_bytes = '0;
        open_topo  = 1'b0;
    endfunction

    // Feeds one sequence byte into the hash and, for pattern bytes 0..3, into the
    // leading-pixel word.
    function automatic void absorb_byte(input logic [7:0] b);
        int q;
        q = int'(seq_pos);
        if (q < int'(used_bytes)) begin
            if (q % 4 == 3) begin
                hash_acc   = murmur_mix(hash_acc, {b, tail_bytes});
                tail_bytes = '0;
            end
            else begin
                tail_bytes = tail_bytes | (24'(b) << (8 * (q % 4)));
            end
        end
        if (q >= 2 && q - 2 < 4 && q - 2 < int'(used_bytes))
            lead_bytes = lead_bytes | (32'(b) << (24 - 8 * (q - 2)));
        seq_pos = (q < int'(POS_SAT)) ? 7'(q + 1) : POS_SAT;
    endfunction

    // Advances the prediction by one input beat; returns 1 when a key is due.
    function automatic bit topology_step(input logic [7:0] row, input logic [7:0] col,
                                         input logic [7:0] pat, input logic last,
                                         output key_result_t res);
        int          area;
        logic [31:0] h;
        bit          usable;
        res = '0;
        if (!open_topo) begin
            area = (int'(row) * int'(col) + 7) >> 3;
            clear_topology();
            open_topo  = 1'b1;
            used_bytes = (area > MAX_PATTERN_BYTES) ? POS_SAT : 7'(area);
            hash_acc   = 32'(used_bytes) ^ MUR_SEED;
            if (used_bytes != 0 && int'(used_bytes) <= MAX_PATTERN_BYTES) begin
                absorb_byte(row);
                absorb_byte(col);
            end
        end
        usable = used_bytes != 0 && int'(used_bytes) <= MAX_PATTERN_BYTES;
        if (usable)
            absorb_byte(pat);
        if (!last)
            return 1'b0;

        if (!usable) begin
            res.key    = '0;
            res.status = (used_bytes == 0) ? ST_NO_PIXELS : ST_OVER_CAP;
        end
        else begin
            // Bytes missing at an early end are hashed as zeros.
            while (seq_pos < used_bytes)
                absorb_byte(8'h00);
            h = hash_acc;
            if (used_bytes[1:0] != 2'd0) begin
                h = h ^ 32'(tail_bytes);
                h = h * MUR_M;
            end
            h = h ^ (h >> 13);
            h = h * MUR_M;
            h = h ^ (h >> 15);
            res.key    = {h, lead_bytes};
            res.status = ST_OK;
        end
        clear_topology();
        return 1'b1;
    endfunction

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        if (fail_count < 10)
            $display("%0t: %s mismatch: expected %h, actual %h", $realtime, what, want, got);
        fail_count++;
    endfunction

    // Predict on every accepted input beat, compare on every accepted result beat.
    always @(posedge clk or negedge rst_n) begin
        key_result_t fresh;
        key_result_t want;
        if (!rst_n) begin
            clear_topology();
            expected_keys.delete();
            fail_count = 0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                if (topology_step(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tlast, fresh))
                    expected_keys.push_back(fresh);
            end
            if (m_tvalid && m_tready) begin
                if (expected_keys.size() == 0) begin
                    report_mismatch("unexpected result beat", 64'd0, m_tdata);
                end
                else begin
                    want = expected_keys.pop_front();
                    if (m_tdata !== want.key)
                        report_mismatch("topology_key", want.key, m_tdata);
                    if (m_tuser !== want.status)
                        report_mismatch("status", 64'(want.status), 64'(m_tuser));
                end
            end
        end
        pending = expected_keys.size();
    end

endmodule

### tb/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;

    localparam int RANDOM_BEATS = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;     // row_span, col_span, pattern_byte
    logic        s_tlast  = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // topology_key
    logic [1:0]  m_tuser;           // status

    int fail_count;
    int pending;
    int beats_sent  = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_served = 1'b0;

    cluster_topology_murmur2_hash i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    topology_key_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offers one beat, with random idle cycles ahead of it outside the calm stretch, and waits until it is taken.
    task automatic send_beat(input logic [7:0] row, input logic [7:0] col,
                             input logic [7:0] pat, input logic last);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pat, col, row};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    // Spans ride on the first beat only; later beats carry random noise there.
    task automatic send_topology(input int rows, input int cols, input int beats,
                                 input int fill);
        logic [7:0] pat;
        for (int i = 0; i < beats; i++) begin
            case (fill)
                FILL_ONES:  pat = 8'hff;
                FILL_ZEROS: pat = 8'h00;
                default:    pat = 8'($urandom);
            endcase
            if (i == 0)
                send_beat(8'(rows), 8'(cols), pat, beats == 1);
            else
                send_beat(8'($urandom), 8'($urandom), pat, i == beats - 1);
        end
    endtask

    // Result side: random stalls, one long hold-off on request, none in the calm stretch.
    initial
    begin
        forever begin
            @(negedge clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else begin
                m_tready <= calm || ($urandom_range(99) >= 38);
            end
        end
    end

    // Ends the run when neither side has moved a beat for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL cluster_topology_murmur2_hash");
                $finish;
            end
        end
    end

    initial
    begin
        int rows;
        int cols;
        int beats;
        int used;
        int full;
        int pick;
        int shape;
        int topo_idx;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed topologies: empty spans, oversize, tiny counts, early end,
        // surplus bytes, the full 64-byte count and a single-beat topology.
        send_topology(0, 5, 1, FILL_RANDOM);
        send_topology(7, 0, 1, FILL_RANDOM);
        send_topology(255, 255, 1, FILL_ONES);
        send_topology(23, 23, 1, FILL_RANDOM);
        send_topology(1, 1, 1, FILL_ONES);
        send_topology(2, 8, 1, FILL_RANDOM);
        send_topology(3, 8, 1, FILL_ONES);
        send_topology(4, 8, 2, FILL_ONES);
        send_topology(5, 8, 3, FILL_ZEROS);
        send_topology(8, 8, 1, FILL_ONES);
        send_topology(3, 5, 4, FILL_RANDOM);
        send_topology(16, 32, 2, FILL_ONES);
        send_topology(9, 7, 6, FILL_RANDOM);

        // Random topologies, mostly well formed with an exact byte count.
        topo_idx = 0;
        while (beats_sent < RANDOM_BEATS) begin
            calm = (topo_idx >= 50 && topo_idx < 70);
            if (topo_idx == 30)
                hold_req = 1'b1;
            pick = $urandom_range(99);
            if (pick < 8) begin
                if ($urandom_range(1) == 1) begin
                    rows = 0;
                    cols = $urandom_range(255);
                end
                else begin
                    rows = $urandom_range(255);
                    cols = 0;
                end
                beats = $urandom_range(1, 4);
            end
            else if (pick < 16) begin
                rows  = $urandom_range(23, 255);
                cols  = $urandom_range(23, 255);
                beats = $urandom_range(1, 4);
            end
            else begin
                if ($urandom_range(4) == 0) begin
                    rows = $urandom_range(1, 16);
                    cols = $urandom_range(1, 32);
                end
                else begin
                    rows = $urandom_range(1, 8);
                    cols = $urandom_range(1, 16);
                end
                used  = (rows * cols + 7) / 8;
                full  = (used > 2) ? used - 2 : 1;
                shape = $urandom_range(99);
                if (shape < 15)
                    beats = $urandom_range(1, full);
                else if (shape < 30)
                    beats = full + $urandom_range(1, 4);
                else
                    beats = full;
            end
            send_topology(rows, cols, beats, FILL_RANDOM);
            topo_idx++;
        end
        calm = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS cluster_topology_murmur2_hash");
        else
            $display("FAIL cluster_topology_murmur2_hash");
        $finish;
    end

endmodule

### cluster_topology_murmur2_hash.f
rtl/ctmh_pkg.sv
rtl/ctmh_ctrl.sv
rtl/ctmh_dpath.sv
rtl/cluster_topology_murmur2_hash.sv
tb/topology_key_checker.sv
tb/tb_top.sv
